@@ rtl/bdem_pkg.sv @@
package bdem_pkg;

  // Fixed field widths
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Default timestamp width inside the block
  localparam int unsigned TIME_BITS_DEF = 32;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LOW,
    REG_DEBOUNCE_TIME,
    REG_HOLD_TIME,
    REG_EVENT_MODE,
    REG_DUAL_SWITCH,
    REG_ON_ENABLE
  } reg_idx_t;

  // Event modes; codes above MODE_REL_REPEAT are inactive
  typedef enum logic [2:0] {
    MODE_RAW,
    MODE_PRESS_ONCE,
    MODE_PRESS_REPEAT,
    MODE_REL_ONCE,
    MODE_REL_REPEAT
  } mode_t;

  typedef struct packed {
    logic             active_low;
    logic [DUR_W-1:0] debounce_time;
    logic [DUR_W-1:0] hold_time;
    logic [2:0]       event_mode;
    logic             dual_switch;
    logic             on_enable;
  } cfg_t;

  typedef struct packed {
    logic status;
    logic fire_on;
    logic fire_off;
  } res_t;

  localparam cfg_t CFG_RESET = '{
    active_low:    1'b1,
    debounce_time: 16'd50,
    hold_time:     16'd1000,
    event_mode:    3'(MODE_RAW),
    dual_switch:   1'b0,
    on_enable:     1'b0
  };

endpackage

@@ rtl/bdem_if.sv @@
interface bdem_in_if;
  logic                         valid;
  logic                         ready;
  logic [bdem_pkg::NOW_W-1:0]   now_ms;
  logic                         pin_level;

  modport source (output valid, now_ms, pin_level, input ready);
  modport sink   (input valid, now_ms, pin_level, output ready);
endinterface

interface bdem_out_if;
  logic valid;
  logic ready;
  logic status;
  logic fire_on;
  logic fire_off;

  modport source (output valid, status, fire_on, fire_off, input ready);
  modport sink   (input valid, status, fire_on, fire_off, output ready);
endinterface

interface bdem_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bdem_pkg::CFG_IDX_W-1:0]    index;
  logic [bdem_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/button_debounce_event_modes_core.sv @@
// Button debouncer with long-press and delayed-release event modes. Each item
// is one poll (millisecond timestamp and raw pin level) and yields exactly one
// result item (status, fire_on, fire_off). A poll is captured in an input
// register, evaluated against the debounce and event state by combinational
// compares and subtractions, and written to the output register, so a poll
// may be accepted every clock cycle unless the output stalls. The output
// register, which offers the result, lets a new poll enter while a
// result still waits. Configuration writes are taken at any time (ready is
// always high) and should be made only while no poll is in flight.
module button_debounce_event_modes_core #(
  parameter int unsigned TIME_BITS = bdem_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bdem_in_if.sink     in_ch,
  bdem_out_if.source  out_ch,
  bdem_cfg_if.sink    cfg_ch
);
  import bdem_pkg::*;

  cfg_t                    cfg;
  logic                    s1_valid;
  logic [NOW_W-1:0]        s1_now;
  logic                    s1_pin;
  logic                    s1_move;
  logic                    out_valid;
  res_t                    out_res;

  logic                    prior_raw;
  logic [TIME_BITS-1:0]    change_time;
  logic                    stable_level;
  logic [TIME_BITS-1:0]    press_start;
  logic                    hold_fired;
  logic                    release_armed;
  logic [TIME_BITS-1:0]    release_start;

  logic                    prior_raw_next;
  logic [TIME_BITS-1:0]    change_time_next;
  logic                    stable_level_next;
  logic [TIME_BITS-1:0]    press_start_next;
  logic                    hold_fired_next;
  logic                    release_armed_next;
  logic [TIME_BITS-1:0]    release_start_next;
  res_t                    res_next;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ACTIVE_LOW:    cfg.active_low    <= cfg_ch.data[0];
        REG_DEBOUNCE_TIME: cfg.debounce_time <= cfg_ch.data[DUR_W-1:0];
        REG_HOLD_TIME:     cfg.hold_time     <= cfg_ch.data[DUR_W-1:0];
        REG_EVENT_MODE:    cfg.event_mode    <= cfg_ch.data[2:0];
        REG_DUAL_SWITCH:   cfg.dual_switch   <= cfg_ch.data[0];
        REG_ON_ENABLE:     cfg.on_enable     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage advances when the output register is empty or being read
  assign s1_move     = s1_valid & (~out_valid | out_ch.ready);
  assign in_ch.ready = ~s1_valid | s1_move;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_now <= in_ch.now_ms;
      s1_pin <= in_ch.pin_level;
    end
  end

  bdem_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .cfg                (cfg),
    .now_ms             (s1_now),
    .pin_level          (s1_pin),
    .prior_raw          (prior_raw),
    .change_time        (change_time),
    .stable_level       (stable_level),
    .press_start        (press_start),
    .hold_fired         (hold_fired),
    .release_armed      (release_armed),
    .release_start      (release_start),
    .prior_raw_next     (prior_raw_next),
    .change_time_next   (change_time_next),
    .stable_level_next  (stable_level_next),
    .press_start_next   (press_start_next),
    .hold_fired_next    (hold_fired_next),
    .release_armed_next (release_armed_next),
    .release_start_next (release_start_next),
    .res                (res_next)
  );

  // Debounce and event state: advance once per evaluated item
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_raw     <= 1'b0;
      change_time   <= '0;
      stable_level  <= 1'b0;
      press_start   <= '0;
      hold_fired    <= 1'b0;
      release_armed <= 1'b0;
      release_start <= '0;
    end else if (s1_move) begin
      prior_raw     <= prior_raw_next;
      change_time   <= change_time_next;
      stable_level  <= stable_level_next;
      press_start   <= press_start_next;
      hold_fired    <= hold_fired_next;
      release_armed <= release_armed_next;
      release_start <= release_start_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res <= res_next;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.status   = out_res.status;
  assign out_ch.fire_on  = out_res.fire_on;
  assign out_ch.fire_off = out_res.fire_off;

  // Checks
  a_inactive_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_move && (cfg.event_mode > 3'(MODE_REL_REPEAT)))
      |=> (out_valid && !out_res.status && !out_res.fire_on && !out_res.fire_off))
    else $error("inactive mode produced a pulse");

  a_on_off_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.fire_on && out_res.fire_off))
    else $error("fire_on and fire_off both set");

  a_off_needs_dual: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> (!out_res.fire_off || $past(cfg.dual_switch)))
    else $error("fire_off without dual switch");

  a_dual_off_tracks_status: assert property (@(posedge clk) disable iff (rst)
    (s1_move && cfg.dual_switch && (cfg.event_mode <= 3'(MODE_REL_REPEAT)))
      |=> (out_res.fire_off == !out_res.status))
    else $error("dual switch off pulse does not follow status");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !$past(s1_move) |-> ($stable(press_start) && $stable(change_time)
                         && $stable(release_start)))
    else $error("state changed without an item");

endmodule

@@ rtl/bdem_eval.sv @@
module bdem_eval #(
  parameter int unsigned TIME_BITS = bdem_pkg::TIME_BITS_DEF
) (
  input  bdem_pkg::cfg_t                 cfg,
  input  logic [bdem_pkg::NOW_W-1:0]     now_ms,
  input  logic                           pin_level,
  input  logic                           prior_raw,
  input  logic [TIME_BITS-1:0]           change_time,
  input  logic                           stable_level,
  input  logic [TIME_BITS-1:0]           press_start,
  input  logic                           hold_fired,
  input  logic                           release_armed,
  input  logic [TIME_BITS-1:0]           release_start,
  output logic                           prior_raw_next,
  output logic [TIME_BITS-1:0]           change_time_next,
  output logic                           stable_level_next,
  output logic [TIME_BITS-1:0]           press_start_next,
  output logic                           hold_fired_next,
  output logic                           release_armed_next,
  output logic [TIME_BITS-1:0]           release_start_next,
  output bdem_pkg::res_t                 res
);
  import bdem_pkg::*;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] deb_t;
  logic [TIME_BITS-1:0] hold_t;
  logic [TIME_BITS-1:0] ct_n;
  logic [TIME_BITS-1:0] ps_n;
  logic [TIME_BITS-1:0] el_change;
  logic [TIME_BITS-1:0] el_press;
  logic [TIME_BITS-1:0] el_ps_old;
  logic [TIME_BITS-1:0] el_release;
  logic                 raw;
  logic                 level;
  logic                 active;
  logic                 trig;
  logic                 st;

  // Timestamps wrap at the internal width
  assign now_t  = TIME_BITS'(now_ms);
  assign deb_t  = TIME_BITS'(cfg.debounce_time);
  assign hold_t = TIME_BITS'(cfg.hold_time);

  // Debounce: restart the stability window on each raw edge
  assign raw       = pin_level ^ cfg.active_low;
  assign ct_n      = (raw != prior_raw) ? now_t : change_time;
  assign el_change = now_t - ct_n;
  assign level     = (el_change >= deb_t) ? raw : stable_level;

  // Press start is taken afresh when zero (not started)
  assign ps_n       = (press_start == '0) ? now_t : press_start;
  assign el_press   = now_t - ps_n;
  assign el_ps_old  = now_t - press_start;
  assign el_release = now_t - release_start;

  assign active = (cfg.event_mode <= 3'(MODE_REL_REPEAT));

  // Mode logic and next state
  always_comb begin
    prior_raw_next     = prior_raw;
    change_time_next   = change_time;
    stable_level_next  = stable_level;
    press_start_next   = press_start;
    hold_fired_next    = hold_fired;
    release_armed_next = release_armed;
    release_start_next = release_start;
    trig               = 1'b1;
    st                 = 1'b0;

    if (active) begin
      prior_raw_next    = raw;
      change_time_next  = ct_n;
      stable_level_next = level;
    end

    case (cfg.event_mode)
      MODE_RAW: begin
        st = level;
      end
      MODE_PRESS_ONCE: begin
        if (level) begin
          press_start_next = ps_n;
          if (!hold_fired && (el_press >= hold_t)) begin
            hold_fired_next = 1'b1;
            st              = 1'b1;
          end
        end else begin
          press_start_next = '0;
          hold_fired_next  = 1'b0;
        end
      end
      MODE_PRESS_REPEAT: begin
        if (level) begin
          press_start_next = ps_n;
          st               = (el_press >= hold_t);
        end else begin
          press_start_next = '0;
        end
      end
      MODE_REL_ONCE: begin
        trig = 1'b0;
        st   = 1'b1;
        if (level) begin
          press_start_next   = now_t;
          release_armed_next = 1'b0;
        end else if (press_start != '0) begin
          if (!release_armed) begin
            if (el_ps_old >= hold_t) begin
              release_armed_next = 1'b1;
            end
          end else begin
            press_start_next   = '0;
            release_armed_next = 1'b0;
            st                 = 1'b0;
          end
        end
      end
      MODE_REL_REPEAT: begin
        trig = 1'b0;
        st   = 1'b1;
        if (level) begin
          release_start_next = now_t;
        end else if ((release_start != '0) && (el_release >= hold_t)) begin
          st = 1'b0;
        end
      end
      default: begin
        st = 1'b0;
      end
    endcase
  end

  // Handler pulses
  always_comb begin
    res = '0;
    if (active) begin
      res.status = st;
      if (cfg.dual_switch) begin
        res.fire_on  = st & cfg.on_enable;
        res.fire_off = ~st;
      end else begin
        res.fire_on  = cfg.on_enable & (st == trig);
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bdem_pkg::*;

  localparam int unsigned HALF_PERIOD    = 10;
  localparam int unsigned RST_CYCLES     = 12;
  localparam int unsigned RX_HOLD_CYCLES = 150;
  localparam int unsigned POLLS_PER_SET  = 48;
  localparam int unsigned SETS_PER_PHASE = 6;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam longint      TIMEOUT_NS     = 64'd200_000 * 2 * HALF_PERIOD;

  // Register index that maps to nothing, and the inactive mode codes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd7;
  localparam logic [2:0]           MODE_IDLE_LO = 3'd5;
  localparam logic [2:0]           MODE_IDLE_HI = 3'd7;

  typedef struct {
    bit                    wr_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [NOW_W-1:0]      now;
    logic                  pin;
    bit                    known;
    res_t                  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  bdem_in_if  in_ch ();
  bdem_out_if out_ch ();
  bdem_cfg_if cfg_ch ();

  button_debounce_event_modes_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Shadow of the register file and the debouncer state
  cfg_t             cfg_sh        = CFG_RESET;
  logic             last_raw      = 1'b0;
  logic [NOW_W-1:0] raw_change_ms = '0;
  logic             deb_level     = 1'b0;
  logic [NOW_W-1:0] press_t0      = '0;
  logic             hold_done     = 1'b0;
  logic             rel_armed     = 1'b0;
  logic [NOW_W-1:0] rel_t0        = '0;

  res_t        poll_result_q[$];
  int unsigned fault_cnt     = 0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 62;
  bit          rx_hold_req   = 1'b0;
  dir_row_t    dir_tab[$];

  function automatic logic [NOW_W-1:0] ms_since(input logic [NOW_W-1:0] now,
                                                input logic [NOW_W-1:0] t0);
    return now - t0;
  endfunction

  // Advance the shadow state by one poll and return the item it should yield
  function automatic res_t predict_poll(input logic [NOW_W-1:0] now, input logic pin);
    res_t r;
    logic raw;
    logic lvl;
    logic trig;
    r = '0;
    trig = 1'b1;
    // inactive modes freeze everything, debouncing included
    if (cfg_sh.event_mode > 3'(MODE_REL_REPEAT))
      return r;
    raw = pin ^ cfg_sh.active_low;
    if (raw != last_raw) begin
      raw_change_ms = now;
      last_raw = raw;
    end
    if (ms_since(now, raw_change_ms) >= cfg_sh.debounce_time)
      deb_level = raw;
    lvl = deb_level;
    case (cfg_sh.event_mode)
      MODE_RAW: begin
        r.status = lvl;
      end
      MODE_PRESS_ONCE: begin
        if (lvl) begin
          // a start time of zero reads as not started
          if (press_t0 == '0)
            press_t0 = now;
          if (!hold_done && ms_since(now, press_t0) >= cfg_sh.hold_time) begin
            hold_done = 1'b1;
            r.status = 1'b1;
          end
        end else begin
          press_t0 = '0;
          hold_done = 1'b0;
        end
      end
      MODE_PRESS_REPEAT: begin
        if (lvl) begin
          if (press_t0 == '0)
            press_t0 = now;
          if (ms_since(now, press_t0) >= cfg_sh.hold_time)
            r.status = 1'b1;
        end else begin
          press_t0 = '0;
        end
      end
      MODE_REL_ONCE: begin
        trig = 1'b0;
        r.status = 1'b1;
        if (lvl) begin
          press_t0 = now;
          rel_armed = 1'b0;
        end else if (press_t0 != '0) begin
          // arm on one poll, fire on the next
          if (!rel_armed) begin
            if (ms_since(now, press_t0) >= cfg_sh.hold_time)
              rel_armed = 1'b1;
          end else begin
            press_t0 = '0;
            rel_armed = 1'b0;
            r.status = 1'b0;
          end
        end
      end
      default: begin
        trig = 1'b0;
        r.status = 1'b1;
        if (lvl)
          rel_t0 = now;
        else if (rel_t0 != '0 && ms_since(now, rel_t0) >= cfg_sh.hold_time)
          r.status = 1'b0;
      end
    endcase
    // form the handler pulses
    if (cfg_sh.dual_switch) begin
      if (r.status)
        r.fire_on = cfg_sh.on_enable;
      else
        r.fire_off = 1'b1;
    end else if (cfg_sh.on_enable && r.status == trig) begin
      r.fire_on = 1'b1;
    end
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{wr_cfg: 1'b1, idx: idx, val: val, now: '0, pin: 1'b0, known: 1'b0, want: '0};
    return row;
  endfunction

  function automatic dir_row_t poll_row(input logic [NOW_W-1:0] now, input logic pin);
    dir_row_t row;
    row = '{wr_cfg: 1'b0, idx: '0, val: '0, now: now, pin: pin, known: 1'b0, want: '0};
    return row;
  endfunction

  function automatic dir_row_t known_row(input logic [NOW_W-1:0] now, input logic pin,
                                         input logic status, input logic on,
                                         input logic off);
    dir_row_t row;
    row = poll_row(now, pin);
    row.known = 1'b1;
    row.want = '{status: status, fire_on: on, fire_off: off};
    return row;
  endfunction

  // Offer one poll, idling first at random; valid is left high after acceptance
  task automatic send_poll(input logic [NOW_W-1:0] now, input logic pin,
                           input bit known = 1'b0, input res_t want = '0);
    res_t r;
    cfg_ch.valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.now_ms    <= now;
    in_ch.pin_level <= pin;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    r = predict_poll(now, pin);
    poll_result_q.push_back(known ? want : r);
  endtask

  // Hold the sender until every pending item has come back
  task automatic drain();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    while (poll_result_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready)
      @(posedge clk);
    // keep only the register's width; unknown indexes drop
    case (idx)
      REG_ACTIVE_LOW:    cfg_sh.active_low    = val[0];
      REG_DEBOUNCE_TIME: cfg_sh.debounce_time = val;
      REG_HOLD_TIME:     cfg_sh.hold_time     = val;
      REG_EVENT_MODE:    cfg_sh.event_mode    = val[2:0];
      REG_DUAL_SWITCH:   cfg_sh.dual_switch   = val[0];
      REG_ON_ENABLE:     cfg_sh.on_enable     = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [DUR_W-1:0] pick_ms();
    if ($urandom_range(0, 9) == 0)
      return DUR_W'($urandom);
    return DUR_W'($urandom_range(0, 40));
  endfunction

  // Presses and releases with bounce at each change, plus some stray polls
  task automatic run_presses(input int unsigned n_polls, input int unsigned step_max);
    logic [NOW_W-1:0] t;
    logic             lvl;
    int unsigned      sent;
    case ($urandom_range(0, 3))
      0: t = '0;
      1: t = '1 - NOW_W'($urandom_range(0, 4 * step_max));
      default: t = $urandom;
    endcase
    lvl = 1'($urandom);
    sent = 0;
    while (sent < n_polls) begin
      if ($urandom_range(0, 29) == 0) begin
        send_poll($urandom_range(0, 1) ? NOW_W'(0) : NOW_W'($urandom), 1'($urandom));
        sent++;
      end else begin
        lvl = ~lvl;
        repeat ($urandom_range(0, 3)) begin
          t += $urandom_range(0, 3);
          send_poll(t, 1'($urandom));
          sent++;
        end
        repeat ($urandom_range(1, 10)) begin
          t += $urandom_range(0, step_max);
          send_poll(t, lvl);
          sent++;
        end
      end
    end
  endtask

  // Output side: random back-pressure, or a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each returned item with the oldest pending one
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{status: out_ch.status, fire_on: out_ch.fire_on, fire_off: out_ch.fire_off};
      if (poll_result_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS)
          $display("%0t: unexpected item status=%b on=%b off=%b",
                   $time, got.status, got.fire_on, got.fire_off);
      end else begin
        want = poll_result_q.pop_front();
        if (got.status !== want.status || got.fire_on !== want.fire_on ||
            got.fire_off !== want.fire_off) begin
          fault_cnt++;
          if (fault_cnt <= MAX_REPORTS)
            $display("%0t: mismatch expected status=%b on=%b off=%b, got status=%b on=%b off=%b",
                     $time, want.status, want.fire_on, want.fire_off,
                     got.status, got.fire_on, got.fire_off);
        end
      end
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : main_seq
    logic [DUR_W-1:0] deb;
    logic [DUR_W-1:0] hold;
    logic [2:0]       mode;

    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.now_ms    <= '0;
    in_ch.pin_level <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    dir_tab = {
      // reset values, time zero, then a debounce that spans the wrap
      known_row(32'd0, 1'b1, 1'b0, 1'b0, 1'b0),
      known_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0),
      poll_row(32'd49, 1'b0),
      reg_row(REG_ON_ENABLE, 16'd1),
      known_row(32'd50, 1'b0, 1'b1, 1'b1, 1'b0),
      // dual switch in raw mode
      reg_row(REG_DUAL_SWITCH, 16'd1),
      poll_row(32'd60, 1'b1),
      poll_row(32'd110, 1'b1),
      // press once, with a press starting at time zero
      reg_row(REG_ACTIVE_LOW, 16'hFFFE),
      reg_row(REG_DEBOUNCE_TIME, 16'd0),
      reg_row(REG_HOLD_TIME, 16'd3),
      reg_row(REG_EVENT_MODE, 16'(MODE_PRESS_ONCE)),
      reg_row(REG_DUAL_SWITCH, 16'd0),
      poll_row(32'd200, 1'b1),
      poll_row(32'd203, 1'b1),
      poll_row(32'd204, 1'b1),
      poll_row(32'd205, 1'b0),
      poll_row(32'd0, 1'b1),
      poll_row(32'd1, 1'b1),
      poll_row(32'd3, 1'b1),
      poll_row(32'd4, 1'b1),
      // press repeat with no hold time
      reg_row(REG_HOLD_TIME, 16'd0),
      reg_row(REG_EVENT_MODE, 16'(MODE_PRESS_REPEAT)),
      poll_row(32'd5, 1'b1),
      poll_row(32'd6, 1'b0),
      // release once: arm, then fire
      reg_row(REG_HOLD_TIME, 16'd2),
      reg_row(REG_EVENT_MODE, 16'(MODE_REL_ONCE)),
      poll_row(32'd10, 1'b1),
      poll_row(32'd11, 1'b0),
      poll_row(32'd12, 1'b0),
      poll_row(32'd13, 1'b0),
      // release repeat at the longest durations
      reg_row(REG_DEBOUNCE_TIME, 16'hFFFF),
      reg_row(REG_HOLD_TIME, 16'hFFFF),
      reg_row(REG_EVENT_MODE, 16'(MODE_REL_REPEAT)),
      poll_row(32'd100, 1'b1),
      poll_row(32'd65635, 1'b1),
      poll_row(32'd65636, 1'b0),
      reg_row(REG_DEBOUNCE_TIME, 16'd0),
      poll_row(32'd65637, 1'b0),
      poll_row(32'd131170, 1'b0),
      // unknown index, then an over-wide mode that lands on an inactive code
      reg_row(REG_SPARE, 16'hFFFF),
      reg_row(REG_EVENT_MODE, 16'hFFFF),
      known_row(32'd7, 1'b1, 1'b0, 1'b0, 1'b0)
    };

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_cfg) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_poll(dir_tab[i].now, dir_tab[i].pin, dir_tab[i].known, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < SETS_PER_PHASE; s++) begin
        // first setting of each of the first two phases takes an extreme of the durations
        if (s == 0 && ph == 0) begin
          deb  = '1;
          hold = '1;
        end else if (s == 0 && ph == 1) begin
          deb  = '0;
          hold = '0;
        end else begin
          deb  = pick_ms();
          hold = pick_ms();
        end
        if ($urandom_range(0, 11) == 0)
          mode = 3'($urandom_range(MODE_IDLE_LO, MODE_IDLE_HI));
        else
          mode = 3'($urandom_range(MODE_RAW, MODE_REL_REPEAT));
        drain();
        write_reg(REG_ACTIVE_LOW, CFG_DATA_W'($urandom));
        write_reg(REG_DEBOUNCE_TIME, deb);
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_EVENT_MODE, {13'($urandom), mode});
        write_reg(REG_DUAL_SWITCH, CFG_DATA_W'($urandom));
        write_reg(REG_ON_ENABLE, CFG_DATA_W'($urandom));
        // stall the output for a while so the block backs up
        if (ph == 0 && s == 2)
          rx_hold_req = 1'b1;
        run_presses(POLLS_PER_SET, (deb > hold ? deb : hold) / 6 + 3);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fault_cnt == 0 && poll_result_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
